// File: hw/rtl/pffl_pkg.sv
// shared types and codes of the page fault frame list manager
`default_nettype none
package pffl_pkg;

  localparam int ADDR_W = 48;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_REGION_BASE = 1'b0;

  localparam logic [2:0] ST_MAPPED        = 3'd0;
  localparam logic [2:0] ST_RESUMED       = 3'd1;
  localparam logic [2:0] ST_ALREADY_VALID = 3'd2;
  localparam logic [2:0] ST_NO_FREE       = 3'd3;
  localparam logic [2:0] ST_TRIMMED       = 3'd4;
  localparam logic [2:0] ST_NOT_ACTIVE    = 3'd5;
  localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd6;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] frame_index;
    logic [9:0] free_count;
    logic [9:0] standby_count;
    logic [9:0] standby_head;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/pffl_ram.sv
// single-port synchronous ram with bit write mask and registered read
`default_nettype none
module pffl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic                     we,
  input  wire logic [WIDTH-1:0]         wmask,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= (mem[addr] & ~wmask) | (wdata & wmask);
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/page_fault_frame_list_manager.sv
// demand paging manager: page table entries, free frames and standby list
//
// Usage: a request (op, address) is taken when start is high and busy is low.
// op 0 handles an access fault, op 1 trims a valid page to the standby list.
// Exactly one result per request is shown on out_data for one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// Steps from accept to result strobe: S_LOOK ends an out-of-range
// address, S_ENT a plain lookup or a mapping from the free list; a trim
// adds S_PUSH, a resume from standby S_UNL and S_UNL2. busy drops in the
// cycle the result is shown, so the next request can follow at once. The
// steps come from the single-port page table ram (read, then write
// back) and the single-port link ram: one neighbor link update per cycle.
// region_base is written through the APB port at byte address 0 (64-bit
// data); it must only be changed while busy is low and no result is due.
// After reset the block clears the valid and transition bits of the page
// table, one entry per cycle, and holds busy high until the last is cleared.
`default_nettype none
module page_fault_frame_list_manager #(
  parameter int PAGES = 512,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire pffl_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  output pffl_pkg::out_item_t                       out_data,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pffl_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [pffl_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [pffl_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  import pffl_pkg::*;

  localparam int FW = $clog2(PAGES);
  localparam int PW = $clog2(PAGES + 1);
  localparam int EW = FW + 2;
  localparam int LW = 2 * PW;
  localparam logic [PW-1:0] END_MARK = PW'(PAGES);
  localparam logic [FW-1:0] LAST_PAGE = FW'(PAGES - 1);
  localparam logic [LW-1:0] MASK_NEXT = {{PW{1'b1}}, {PW{1'b0}}};
  localparam logic [LW-1:0] MASK_PREV = {{PW{1'b0}}, {PW{1'b1}}};

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_ENT  = 3'd3;
  localparam logic [2:0] S_UNL  = 3'd4;
  localparam logic [2:0] S_UNL2 = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [FW-1:0]     clr_r, clr_nxt;
  logic              op_r, op_nxt;
  logic [FW-1:0]     pg_r, pg_nxt;
  logic              oor_r, oor_nxt;
  logic [FW-1:0]     frame_r, frame_nxt;
  logic [PW-1:0]     lnext_r, lnext_nxt;
  logic [PW-1:0]     lprev_r, lprev_nxt;
  logic [PW-1:0]     free_left_r, free_left_nxt;
  logic [PW-1:0]     total_r, total_nxt;
  logic [PW-1:0]     first_r, first_nxt;
  logic [ADDR_W-1:0] base_r;
  logic              out_valid_r, emit;
  out_item_t         out_r;
  logic [2:0]        st;
  logic [FW-1:0]     frm;
  logic [PW-1:0]     fl_dec;

  logic [ADDR_W-1:0] diff, pg_full;
  logic              oor_in;

  logic [FW-1:0]     ent_addr;
  logic              ent_we;
  logic [EW-1:0]     ent_wdata, ent_q;
  logic              ent_v, ent_t;
  logic [FW-1:0]     ent_f;

  logic [FW-1:0]     lnk_addr;
  logic              lnk_we;
  logic [LW-1:0]     lnk_wmask, lnk_wdata, lnk_q;
  logic [PW-1:0]     lnk_n, lnk_p;

  pffl_ram #(.WIDTH(EW), .DEPTH(PAGES)) u_entry_ram (
    .clk   (clk),
    .addr  (ent_addr),
    .we    (ent_we),
    .wmask ({EW{1'b1}}),
    .wdata (ent_wdata),
    .rdata (ent_q)
  );

  pffl_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_link_ram (
    .clk   (clk),
    .addr  (lnk_addr),
    .we    (lnk_we),
    .wmask (lnk_wmask),
    .wdata (lnk_wdata),
    .rdata (lnk_q)
  );

  assign diff    = in_data.address - base_r;
  assign pg_full = diff >> PAGE_SHIFT;
  assign oor_in  = (in_data.address < base_r) || (pg_full >= ADDR_W'(PAGES));

  assign ent_v = ent_q[EW-1];
  assign ent_t = ent_q[EW-2];
  assign ent_f = ent_q[FW-1:0];
  assign lnk_n = lnk_q[LW-1:PW];
  assign lnk_p = lnk_q[PW-1:0];
  assign fl_dec = free_left_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    pg_nxt        = pg_r;
    oor_nxt       = oor_r;
    frame_nxt     = frame_r;
    lnext_nxt     = lnext_r;
    lprev_nxt     = lprev_r;
    free_left_nxt = free_left_r;
    total_nxt     = total_r;
    first_nxt     = first_r;
    ent_addr      = pg_r;
    ent_we        = 1'b0;
    ent_wdata     = '0;
    lnk_addr      = frame_r;
    lnk_we        = 1'b0;
    lnk_wmask     = '1;
    lnk_wdata     = '0;
    emit          = 1'b0;
    st            = ST_MAPPED;
    frm           = '0;
    unique case (state_r)
      S_CLR: begin
        ent_addr = clr_r;
        ent_we   = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_PAGE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.op;
          pg_nxt    = pg_full[FW-1:0];
          oor_nxt   = oor_in;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (oor_r) begin
          emit      = 1'b1;
          st        = ST_OUT_OF_RANGE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        frame_nxt = ent_f;
        state_nxt = S_IDLE;
        if (!op_r) begin
          priority if (ent_v) begin
            emit = 1'b1;
            st   = ST_ALREADY_VALID;
            frm  = ent_f;
          end else if (ent_t) begin
            ent_we    = 1'b1;
            ent_wdata = {1'b1, 1'b0, ent_f};
            lnk_addr  = ent_f;
            state_nxt = S_UNL;
          end else if (free_left_r == '0) begin
            emit = 1'b1;
            st   = ST_NO_FREE;
          end else begin
            free_left_nxt = fl_dec;
            ent_we        = 1'b1;
            ent_wdata     = {1'b1, 1'b0, fl_dec[FW-1:0]};
            emit          = 1'b1;
            st            = ST_MAPPED;
            frm           = fl_dec[FW-1:0];
          end
        end else begin
          if (ent_v) begin
            ent_we    = 1'b1;
            ent_wdata = {1'b0, 1'b1, ent_f};
            lnk_addr  = ent_f;
            lnk_we    = 1'b1;
            lnk_wdata = {first_r, END_MARK};
            state_nxt = S_PUSH;
          end else begin
            emit = 1'b1;
            st   = ST_NOT_ACTIVE;
          end
        end
      end
      S_UNL: begin
        lnext_nxt = lnk_n;
        lprev_nxt = lnk_p;
        if (lnk_p == END_MARK) begin
          first_nxt = lnk_n;
        end else begin
          lnk_addr  = lnk_p[FW-1:0];
          lnk_we    = 1'b1;
          lnk_wmask = MASK_NEXT;
          lnk_wdata = {lnk_n, {PW{1'b0}}};
        end
        state_nxt = S_UNL2;
      end
      S_UNL2: begin
        if (lnext_r != END_MARK) begin
          lnk_addr  = lnext_r[FW-1:0];
          lnk_we    = 1'b1;
          lnk_wmask = MASK_PREV;
          lnk_wdata = {{PW{1'b0}}, lprev_r};
        end
        total_nxt = total_r - PW'(total_r != '0);
        emit      = 1'b1;
        st        = ST_RESUMED;
        frm       = frame_r;
        state_nxt = S_IDLE;
      end
      S_PUSH: begin
        if (first_r != END_MARK) begin
          lnk_addr  = first_r[FW-1:0];
          lnk_we    = 1'b1;
          lnk_wmask = MASK_PREV;
          lnk_wdata = {{PW{1'b0}}, PW'(frame_r)};
        end
        first_nxt = PW'(frame_r);
        total_nxt = total_r + 1'b1;
        emit      = 1'b1;
        st        = ST_TRIMMED;
        frm       = frame_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      free_left_r <= END_MARK;
      total_r     <= '0;
      first_r     <= END_MARK;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_left_r <= free_left_nxt;
      total_r     <= total_nxt;
      first_r     <= first_nxt;
      out_valid_r <= emit;
      if (psel && penable && pwrite && paddr == REG_REGION_BASE) begin
        base_r <= pwdata[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pg_r    <= pg_nxt;
    oor_r   <= oor_nxt;
    frame_r <= frame_nxt;
    lnext_r <= lnext_nxt;
    lprev_r <= lprev_nxt;
    if (emit) begin
      out_r.status        <= st;
      out_r.frame_index   <= 9'(frm);
      out_r.free_count    <= 10'(free_left_nxt);
      out_r.standby_count <= 10'(total_nxt);
      out_r.standby_head  <= 10'(first_nxt);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_REGION_BASE) ? CFG_DATA_W'(base_r) : '0;

endmodule
`default_nettype wire
